// File: design/cfvl_pkg.sv
package cfvl_pkg;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REFRESHED = 2'd1,
        ST_EVICTED  = 2'd2
    } add_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PICK,
        S_DONE
    } eng_state_t;

    typedef struct packed {
        req_t        req_type;
        logic [31:0] content_name;
        logic [15:0] version;
        logic [7:0]  port;
        logic [31:0] new_hop_addr;
    } req_item_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] hop_addr;
        logic [7:0]  out_port;
        logic [1:0]  status;
        logic [5:0]  removed_count;
    } rsp_item_t;

    localparam int ReqBits = $bits(req_item_t);
    localparam int RspBits = $bits(rsp_item_t);

endpackage

// File: design/cfvl_queue.sv
module cfvl_queue
    import cfvl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  req_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output req_item_t out_item
);

    // Two-entry request queue between the port and the table engine.
    req_item_t  mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: design/cfvl_engine.sv
module cfvl_engine
    import cfvl_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int DOWN_PORTS  = 4,
    parameter int UP_PORTS    = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [7:0] down_port_limit,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = $clog2(DOWN_PORTS + 2);
    localparam int UW = $clog2(UP_PORTS + 2);
    localparam int KW = (DW > UW) ? DW : UW;
    localparam int DIW = (DOWN_PORTS > 1) ? $clog2(DOWN_PORTS) : 1;
    localparam int UIW = (UP_PORTS > 1) ? $clog2(UP_PORTS) : 1;

    // The table is a register file shifted in place: a write at a slot
    // with compaction done one slot per cycle.
    logic [31:0] name_reg [TABLE_DEPTH];
    logic [15:0] ver_reg  [TABLE_DEPTH];
    logic [31:0] hop_reg  [TABLE_DEPTH];
    logic [7:0]  port_reg [TABLE_DEPTH];

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;     // scan position
    logic [CW-1:0] sh_reg, sh_next;       // shift position
    logic          sh_up_reg, sh_up_next; // 1: shift toward tail for add
    logic          sh_ret_reg, sh_ret_next; // 1: return to scan after shift
    eng_state_t    state_reg, state_next;
    req_item_t     cur_reg;
    logic          cur_load;

    logic [31:0] dn_hop_reg [DOWN_PORTS];
    logic [7:0]  dn_port_reg [DOWN_PORTS];
    logic [31:0] up_hop_reg [UP_PORTS];
    logic [7:0]  up_port_reg [UP_PORTS];
    logic [DW-1:0] dn_reg, dn_next;
    logic [UW-1:0] up_reg, up_next;
    logic          dn_wr, up_wr;

    logic [5:0]  rem_reg, rem_next;
    logic [1:0]  status_reg, status_next;
    logic        hit_reg, hit_next;
    logic [31:0] nh_reg, nh_next;
    logic [7:0]  op_reg, op_next;

    // modulo by a small count: restoring division, one quotient bit per cycle
    logic [31:0]   mod_q_reg, mod_q_next;
    logic [KW:0]   mod_r_reg, mod_r_next;
    logic [5:0]    mod_i_reg, mod_i_next;
    logic [KW-1:0] mod_d_reg, mod_d_next;
    logic          mod_dn_reg, mod_dn_next;
    logic [KW:0]   mod_trial;

    // Table write controls
    logic          do_shift;     // move one slot
    logic          wr_head;      // write slot 0
    logic [31:0]   head_name, head_hop;
    logic [15:0]   head_ver;
    logic [7:0]    head_port;
    logic [31:0]   mv_name_reg, mv_hop_reg;
    logic [15:0]   mv_ver_reg;
    logic [7:0]    mv_port_reg;
    logic          mv_load;

    logic [IW-1:0] ix;
    logic [IW-1:0] sx;
    logic          name_eq, port_eq;

    assign ix      = idx_reg[IW-1:0];
    assign sx      = sh_reg[IW-1:0];
    assign name_eq = (name_reg[ix] == cur_reg.content_name);
    assign port_eq = (port_reg[ix] == cur_reg.port);
    assign mod_trial = {mod_r_reg[KW-1:0], mod_q_reg[31]};

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_DONE);
    assign rsp = '{hit: hit_reg, hop_addr: nh_reg, out_port: op_reg,
                   status: status_reg, removed_count: rem_reg};

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        sh_next     = sh_reg;
        sh_up_next  = sh_up_reg;
        sh_ret_next = sh_ret_reg;
        dn_next     = dn_reg;
        up_next     = up_reg;
        dn_wr       = 1'b0;
        up_wr       = 1'b0;
        rem_next    = rem_reg;
        status_next = status_reg;
        hit_next    = hit_reg;
        nh_next     = nh_reg;
        op_next     = op_reg;
        mod_q_next  = mod_q_reg;
        mod_r_next  = mod_r_reg;
        mod_i_next  = mod_i_reg;
        mod_d_next  = mod_d_reg;
        mod_dn_next = mod_dn_reg;
        cur_load    = 1'b0;
        mv_load     = 1'b0;
        do_shift    = 1'b0;
        wr_head     = 1'b0;
        head_name   = mv_name_reg;
        head_ver    = mv_ver_reg;
        head_hop    = mv_hop_reg;
        head_port   = mv_port_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cur_load    = 1'b1;
                    idx_next    = '0;
                    dn_next     = '0;
                    up_next     = '0;
                    rem_next    = '0;
                    status_next = ST_INSERTED;
                    hit_next    = 1'b0;
                    nh_next     = '0;
                    op_next     = '0;
                    state_next  = (req.req_type == REQ_NONE) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_reg >= count_reg)
                begin
                    if (cur_reg.req_type == REQ_ADD)
                    begin
                        // No name+port hit: push a new entry at the head.
                        status_next = (count_reg == CW'(TABLE_DEPTH)) ? ST_EVICTED
                                                                      : ST_INSERTED;
                        mv_load     = 1'b1;
                        sh_up_next  = 1'b1;
                        sh_ret_next = 1'b0;
                        if (count_reg == CW'(TABLE_DEPTH))
                        begin
                            sh_next = CW'(TABLE_DEPTH - 1);
                        end
                        else
                        begin
                            sh_next    = count_reg;
                            count_next = count_reg + 1'b1;
                        end
                        state_next = S_SHIFT;
                    end
                    else if (cur_reg.req_type == REQ_LOOKUP)
                    begin
                        state_next = S_PICK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (cur_reg.req_type == REQ_ADD)
                begin
                    if (name_eq && port_eq)
                    begin
                        status_next = ST_REFRESHED;
                        mv_load     = 1'b1;
                        sh_up_next  = 1'b1;
                        sh_ret_next = 1'b0;
                        sh_next     = idx_reg;
                        state_next  = S_SHIFT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (cur_reg.req_type == REQ_DELETE)
                begin
                    if (name_eq && port_eq)
                    begin
                        rem_next    = rem_reg + 1'b1;
                        sh_up_next  = 1'b0;
                        sh_ret_next = 1'b1;
                        sh_next     = idx_reg;
                        count_next  = count_reg - 1'b1;
                        state_next  = S_SHIFT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    if (!name_eq)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                    else if ((cur_reg.version > ver_reg[ix]) ||
                             ((cur_reg.version == ver_reg[ix]) && port_eq))
                    begin
                        sh_up_next  = 1'b0;
                        sh_ret_next = 1'b1;
                        sh_next     = idx_reg;
                        count_next  = count_reg - 1'b1;
                        state_next  = S_SHIFT;
                    end
                    else if (cur_reg.version == ver_reg[ix])
                    begin
                        idx_next = idx_reg + 1'b1;
                        if (port_reg[ix] < down_port_limit)
                        begin
                            dn_wr   = (dn_reg < DW'(DOWN_PORTS));
                            dn_next = dn_reg + 1'b1;
                            if (dn_reg == DW'(DOWN_PORTS))
                            begin
                                state_next = S_PICK;
                            end
                        end
                        else
                        begin
                            up_wr   = (up_reg < UW'(UP_PORTS));
                            up_next = up_reg + 1'b1;
                            if (up_reg == UW'(UP_PORTS))
                            begin
                                state_next = S_PICK;
                            end
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                if (state_next == S_PICK)
                begin
                    mod_q_next = cur_reg.content_name;
                    mod_r_next = '0;
                    mod_i_next = '0;
                    if ((dn_next != '0) && (dn_next <= DW'(DOWN_PORTS)))
                    begin
                        mod_dn_next = 1'b1;
                        mod_d_next  = KW'(dn_next);
                    end
                    else
                    begin
                        mod_dn_next = 1'b0;
                        mod_d_next  = KW'(up_next);
                    end
                end
            end
            S_SHIFT:
            begin
                if (sh_up_reg)
                begin
                    // Toward the tail; slot 0 takes the saved entry at the end.
                    if (sh_reg == '0)
                    begin
                        wr_head    = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        do_shift = 1'b1;
                        sh_next  = sh_reg - 1'b1;
                    end
                end
                else
                begin
                    if (sh_reg + 1'b1 >= count_reg + 1'b1)
                    begin
                        state_next = sh_ret_reg ? S_SCAN : S_DONE;
                    end
                    else
                    begin
                        do_shift = 1'b1;
                        sh_next  = sh_reg + 1'b1;
                    end
                end
            end
            S_PICK:
            begin
                if (mod_d_reg == '0 || (!mod_dn_reg && up_reg > UW'(UP_PORTS)))
                begin
                    state_next = S_DONE;
                end
                else if (mod_i_reg == 6'd32)
                begin
                    hit_next = 1'b1;
                    if (mod_dn_reg)
                    begin
                        nh_next = dn_hop_reg[mod_r_reg[DIW-1:0]];
                        op_next = dn_port_reg[mod_r_reg[DIW-1:0]];
                    end
                    else
                    begin
                        nh_next = up_hop_reg[mod_r_reg[UIW-1:0]];
                        op_next = up_port_reg[mod_r_reg[UIW-1:0]];
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    mod_q_next = {mod_q_reg[30:0], 1'b0};
                    mod_i_next = mod_i_reg + 1'b1;
                    if (mod_trial >= {1'b0, mod_d_reg})
                    begin
                        mod_r_next = mod_trial - {1'b0, mod_d_reg};
                    end
                    else
                    begin
                        mod_r_next = mod_trial;
                    end
                end
            end
            S_DONE:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cur_load)
        begin
            cur_reg <= req;
        end
        if (mv_load)
        begin
            if (cur_reg.req_type == REQ_ADD && idx_reg < count_reg)
            begin
                mv_name_reg <= name_reg[ix];
                mv_ver_reg  <= ver_reg[ix];
                mv_hop_reg  <= hop_reg[ix];
                mv_port_reg <= port_reg[ix];
            end
            else
            begin
                mv_name_reg <= cur_reg.content_name;
                mv_ver_reg  <= cur_reg.version;
                mv_hop_reg  <= cur_reg.new_hop_addr;
                mv_port_reg <= cur_reg.port;
            end
        end
        if (do_shift)
        begin
            if (sh_up_reg)
            begin
                name_reg[sx] <= name_reg[sx - 1'b1];
                ver_reg[sx]  <= ver_reg[sx - 1'b1];
                hop_reg[sx]  <= hop_reg[sx - 1'b1];
                port_reg[sx] <= port_reg[sx - 1'b1];
            end
            else
            begin
                name_reg[sx] <= name_reg[sx + 1'b1];
                ver_reg[sx]  <= ver_reg[sx + 1'b1];
                hop_reg[sx]  <= hop_reg[sx + 1'b1];
                port_reg[sx] <= port_reg[sx + 1'b1];
            end
        end
        if (wr_head)
        begin
            name_reg[0] <= head_name;
            ver_reg[0]  <= head_ver;
            hop_reg[0]  <= head_hop;
            port_reg[0] <= head_port;
        end
        if (dn_wr)
        begin
            dn_hop_reg[dn_reg[DIW-1:0]]  <= hop_reg[ix];
            dn_port_reg[dn_reg[DIW-1:0]] <= port_reg[ix];
        end
        if (up_wr)
        begin
            up_hop_reg[up_reg[UIW-1:0]]  <= hop_reg[ix];
            up_port_reg[up_reg[UIW-1:0]] <= port_reg[ix];
        end
        mod_q_reg   <= mod_q_next;
        mod_r_reg   <= mod_r_next;
        mod_i_reg   <= mod_i_next;
        mod_d_reg   <= mod_d_next;
        mod_dn_reg  <= mod_dn_next;
        sh_reg      <= sh_next;
        sh_up_reg   <= sh_up_next;
        sh_ret_reg  <= sh_ret_next;
        idx_reg     <= idx_next;
        dn_reg      <= dn_next;
        up_reg      <= up_next;
        rem_reg     <= rem_next;
        status_reg  <= status_next;
        hit_reg     <= hit_next;
        nh_reg      <= nh_next;
        op_reg      <= op_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: design/content_fib_versioned_lookup.sv
// The table engine scans the entries, shifts slots one by one for each entry
// removed or put at the head, and ends a lookup that found candidates with a
// bit-serial modulo.
// Throughput: one transaction at a time in the table engine; a two-entry queue
// takes new requests meanwhile. Reset empties the table and sets the limit to 16.
module content_fib_versioned_lookup
    import cfvl_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int DOWN_PORTS  = 4,
    parameter int UP_PORTS    = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,  // content_name, version, port, new_hop_addr
    input  logic [1:0]  s_tuser,  // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // hop_addr, out_port, status, removed_count
    output logic        m_tuser   // hit
);

    logic [7:0] limit_reg;
    req_item_t  in_item, q_item;
    logic       q_valid, q_ready;
    rsp_item_t  rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 8'd16;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    assign in_item = '{req_type: req_t'(s_tuser), content_name: s_tdata[31:0],
                       version: s_tdata[47:32], port: s_tdata[55:48],
                       new_hop_addr: s_tdata[87:56]};

    cfvl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    cfvl_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DOWN_PORTS  (DOWN_PORTS),
        .UP_PORTS    (UP_PORTS)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .down_port_limit (limit_reg),
        .req_valid       (q_valid),
        .req_ready       (q_ready),
        .req             (q_item),
        .rsp_valid       (m_tvalid),
        .rsp_ready       (m_tready),
        .rsp             (rsp)
    );

    assign m_tuser = rsp.hit;
    assign m_tdata = {rsp.removed_count, rsp.status, rsp.out_port, rsp.hop_addr};

endmodule

// File: test/content_fib_versioned_lookup_tb.sv
`timescale 1ns / 100ps

module content_fib_versioned_lookup_tb;
    import cfvl_pkg::*;

    localparam int DEPTH = 32;
    localparam int DN_MAX = 4;
    localparam int UP_MAX = 4;
    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // content_name, version, port, new_hop_addr
    logic [1:0]  s_tuser;   // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // hop_addr, out_port, status, removed_count
    logic        m_tuser;   // hit

    content_fib_versioned_lookup i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Shadow copy of the forwarding table, head at index 0.
    logic [31:0] fib_name [DEPTH];
    logic [15:0] fib_ver  [DEPTH];
    logic [31:0] fib_hop  [DEPTH];
    logic [7:0]  fib_port [DEPTH];
    int          fib_count;
    logic [7:0]  down_limit;

    req_item_t   request_q [$];
    rsp_item_t   expected_rsp_q [$];
    int          errors;
    int          rsp_seen;
    logic [31:0] name_pool [6];

    function automatic void drop_slot(int i);
        for (int j = i; j + 1 < fib_count; j++)
        begin
            fib_name[j] = fib_name[j + 1];
            fib_ver[j]  = fib_ver[j + 1];
            fib_hop[j]  = fib_hop[j + 1];
            fib_port[j] = fib_port[j + 1];
        end
        fib_count--;
    endfunction

    function automatic void shift_toward_tail(int top);
        for (int j = top; j > 0; j--)
        begin
            fib_name[j] = fib_name[j - 1];
            fib_ver[j]  = fib_ver[j - 1];
            fib_hop[j]  = fib_hop[j - 1];
            fib_port[j] = fib_port[j - 1];
        end
    endfunction

    function automatic rsp_item_t predict_fib(req_item_t r);
        rsp_item_t   rsp;
        logic [31:0] dn_hop [DN_MAX + 1];
        logic [7:0]  dn_port [DN_MAX + 1];
        logic [31:0] up_hop [UP_MAX + 1];
        logic [7:0]  up_port [UP_MAX + 1];
        int          dn;
        int          up;
        int          i;
        int          k;
        bit          found;
        logic [31:0] t_name;
        logic [15:0] t_ver;
        logic [31:0] t_hop;
        logic [7:0]  t_port;
        rsp = '0;
        dn = 0;
        up = 0;
        i = 0;
        found = 0;
        case (r.req_type)
            REQ_LOOKUP:
            begin
                while (i < fib_count)
                begin
                    if (fib_name[i] != r.content_name)
                    begin
                        i++;
                        continue;
                    end
                    if (r.version > fib_ver[i])
                    begin
                        drop_slot(i);
                        continue;
                    end
                    if (r.version == fib_ver[i])
                    begin
                        if (fib_port[i] == r.port)
                        begin
                            drop_slot(i);
                            continue;
                        end
                        if (fib_port[i] < down_limit)
                        begin
                            dn_hop[dn] = fib_hop[i];
                            dn_port[dn] = fib_port[i];
                            dn++;
                        end
                        else
                        begin
                            up_hop[up] = fib_hop[i];
                            up_port[up] = fib_port[i];
                            up++;
                        end
                        if (dn > DN_MAX || up > UP_MAX)
                            break;
                    end
                    i++;
                end
                if (dn > 0 && dn <= DN_MAX)
                begin
                    k = int'(r.content_name % 32'(dn));
                    rsp.hit = 1'b1;
                    rsp.hop_addr = dn_hop[k];
                    rsp.out_port = dn_port[k];
                end
                else if (up > 0 && up <= UP_MAX)
                begin
                    k = int'(r.content_name % 32'(up));
                    rsp.hit = 1'b1;
                    rsp.hop_addr = up_hop[k];
                    rsp.out_port = up_port[k];
                end
            end
            REQ_ADD:
            begin
                for (i = 0; i < fib_count; i++)
                begin
                    if (fib_name[i] == r.content_name && fib_port[i] == r.port)
                    begin
                        found = 1;
                        break;
                    end
                end
                if (found)
                begin
                    t_name = fib_name[i];
                    t_ver  = fib_ver[i];
                    t_hop  = fib_hop[i];
                    t_port = fib_port[i];
                    shift_toward_tail(i);
                    fib_name[0] = t_name;
                    fib_ver[0]  = t_ver;
                    fib_hop[0]  = t_hop;
                    fib_port[0] = t_port;
                    rsp.status = ST_REFRESHED;
                end
                else
                begin
                    rsp.status = (fib_count >= DEPTH) ? ST_EVICTED : ST_INSERTED;
                    if (fib_count >= DEPTH)
                        fib_count = DEPTH - 1;
                    shift_toward_tail(fib_count);
                    fib_name[0] = r.content_name;
                    fib_ver[0]  = r.version;
                    fib_hop[0]  = r.new_hop_addr;
                    fib_port[0] = r.port;
                    fib_count++;
                end
            end
            REQ_DELETE:
            begin
                while (i < fib_count)
                begin
                    if (fib_name[i] == r.content_name && fib_port[i] == r.port)
                    begin
                        drop_slot(i);
                        rsp.removed_count++;
                    end
                    else
                        i++;
                end
            end
            default:
                rsp = '0;
        endcase
        return rsp;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s at response %0d: got %0h, expected %0h",
                 field, rsp_seen, got, want);
        errors++;
    endtask

    function automatic req_item_t make_req(req_t kind, logic [31:0] name, logic [15:0] ver,
                                           logic [7:0] port, logic [31:0] hop);
        req_item_t r;
        r.req_type = kind;
        r.content_name = name;
        r.version = ver;
        r.port = port;
        r.new_hop_addr = hop;
        return r;
    endfunction

    // Mostly a small set of names, versions and one-hot ports so that entries collide.
    function automatic req_item_t random_req();
        int          sel;
        req_t        kind;
        logic [31:0] name;
        logic [15:0] ver;
        logic [7:0]  port;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            kind = REQ_LOOKUP;
        else if (sel < 85)
            kind = REQ_ADD;
        else if (sel < 97)
            kind = REQ_DELETE;
        else
            kind = REQ_NONE;
        name = ($urandom_range(0, 9) == 0) ? $urandom() : name_pool[$urandom_range(0, 5)];
        sel = $urandom_range(0, 9);
        if (sel == 0)
            ver = 16'($urandom());
        else if (sel == 1)
            ver = 16'hFFFF;
        else
            ver = 16'($urandom_range(0, 2));
        port = ($urandom_range(0, 4) == 0) ? 8'($urandom()) : 8'(1 << $urandom_range(0, 7));
        return make_req(kind, name, ver, port, $urandom());
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Request driver.
    int  send_gap;
    bit  send_burst;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap <= 0;
            send_burst <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            expected_rsp_q.push_back(predict_fib(request_q.pop_front()));
            if ($urandom_range(0, 39) == 0)
                send_burst <= ~send_burst;
            if (send_burst || $urandom_range(0, 11) == 0)
            begin
                if (request_q.size() != 0)
                begin
                    s_tdata <= {8'h00, request_q[0].new_hop_addr, request_q[0].port,
                                request_q[0].version, request_q[0].content_name};
                    s_tuser <= request_q[0].req_type;
                end
                s_tvalid <= (request_q.size() != 0);
                send_gap <= 0;
            end
            else
            begin
                s_tvalid <= 1'b0;
                send_gap <= $urandom_range(0, 11);
            end
        end
        else if (!s_tvalid)
        begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else if (request_q.size() != 0)
            begin
                s_tdata <= {8'h00, request_q[0].new_hop_addr, request_q[0].port,
                            request_q[0].version, request_q[0].content_name};
                s_tuser <= request_q[0].req_type;
                s_tvalid <= 1'b1;
            end
        end
    end

    // Response monitor and ready control, with one long hold-off to back up the block.
    int  recv_gap;
    bit  recv_burst;
    int  hold_left;
    bit  hold_done;
    always @(posedge clk or negedge rst_n)
    begin
        rsp_item_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap <= 0;
            recv_burst <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $display("unexpected response transaction %0h/%0h", m_tuser, m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (m_tuser !== want.hit)
                        report_mismatch("hit", 32'(m_tuser), 32'(want.hit));
                    if (m_tdata[31:0] !== want.hop_addr)
                        report_mismatch("hop_addr", m_tdata[31:0], want.hop_addr);
                    if (m_tdata[39:32] !== want.out_port)
                        report_mismatch("out_port", 32'(m_tdata[39:32]), 32'(want.out_port));
                    if (m_tdata[41:40] !== want.status)
                        report_mismatch("status", 32'(m_tdata[41:40]), 32'(want.status));
                    if (m_tdata[47:42] !== want.removed_count)
                        report_mismatch("removed_count", 32'(m_tdata[47:42]),
                                        32'(want.removed_count));
                end
                rsp_seen++;
                if ($urandom_range(0, 39) == 0)
                    recv_burst <= ~recv_burst;
                if (!hold_done && rsp_seen == 300)
                begin
                    hold_done <= 1'b1;
                    hold_left <= 600;
                    m_tready <= 1'b0;
                end
                else if (recv_burst || $urandom_range(0, 11) == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    recv_gap <= $urandom_range(0, 11);
                end
            end
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
            else if (!m_tready)
            begin
                if (recv_gap > 0)
                    recv_gap <= recv_gap - 1;
                else
                    m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no transaction on either side.
    int idle_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_idle();
        while (request_q.size() != 0 || expected_rsp_q.size() != 0 || s_tvalid)
            @(posedge clk);
    endtask

    task automatic write_limit(logic [7:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        down_limit = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [7:0] limits [5];
        errors = 0;
        rsp_seen = 0;
        fib_count = 0;
        down_limit = 8'd16;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        name_pool[0] = 32'h0;
        name_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 6; i++)
            name_pool[i] = $urandom();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Five down candidates of one version overflow the down list; the up one is used.
        request_q.push_back(make_req(REQ_ADD, 32'd5, 16'd7, 8'h01, 32'h0A000001));
        request_q.push_back(make_req(REQ_ADD, 32'd5, 16'd7, 8'h02, 32'h0A000002));
        request_q.push_back(make_req(REQ_ADD, 32'd5, 16'd7, 8'h04, 32'h0A000004));
        request_q.push_back(make_req(REQ_ADD, 32'd5, 16'd7, 8'h08, 32'h0A000008));
        request_q.push_back(make_req(REQ_ADD, 32'd5, 16'd7, 8'h03, 32'h0A000003));
        request_q.push_back(make_req(REQ_ADD, 32'd5, 16'd7, 8'h20, 32'h0A000020));
        request_q.push_back(make_req(REQ_LOOKUP, 32'd5, 16'd7, 8'h80, 32'h0));
        request_q.push_back(make_req(REQ_LOOKUP, 32'd5, 16'd7, 8'h01, 32'h0));
        request_q.push_back(make_req(REQ_LOOKUP, 32'd5, 16'd7, 8'h80, 32'h0));
        request_q.push_back(make_req(REQ_ADD, 32'd5, 16'd9, 8'h02, 32'hDEAD0000));
        request_q.push_back(make_req(REQ_LOOKUP, 32'd5, 16'd6, 8'h80, 32'h0));
        request_q.push_back(make_req(REQ_LOOKUP, 32'd5, 16'd8, 8'h80, 32'h0));
        request_q.push_back(make_req(REQ_ADD, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
        request_q.push_back(make_req(REQ_ADD, 32'h0, 16'h0, 8'h00, 32'h0));
        request_q.push_back(make_req(REQ_ADD, 32'hFFFF_FFFF, 16'hFFFF, 8'h10, 32'h12345678));
        request_q.push_back(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, 16'h0, 8'h01, 32'h0));
        request_q.push_back(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 8'h01, 32'h0));
        request_q.push_back(make_req(REQ_LOOKUP, 32'h0, 16'h0, 8'h80, 32'h0));
        request_q.push_back(make_req(REQ_DELETE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'h0));
        request_q.push_back(make_req(REQ_DELETE, 32'h0, 16'h0, 8'h00, 32'h0));
        request_q.push_back(make_req(REQ_NONE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
        wait_idle();

        // Zero makes every candidate an up port; the extremes and a mid value follow.
        limits[0] = 8'd16;
        limits[1] = 8'd0;
        limits[2] = 8'd255;
        limits[3] = 8'd1;
        limits[4] = 8'($urandom_range(2, 254));
        for (int p = 0; p < 5; p++)
        begin
            write_limit(limits[p]);
            for (int n = 0; n < 400; n++)
                request_q.push_back(random_req());
            wait_idle();
        end

        repeat (1500) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
design/cfvl_pkg.sv
design/cfvl_queue.sv
design/cfvl_engine.sv
design/content_fib_versioned_lookup.sv
test/content_fib_versioned_lookup_tb.sv
